// ===== rtl/core/ilw_pkg.sv =====
// ----------------------------------------------------------------------------
// ilw_pkg
// Shared constants, register indexes and line codes for the ichimoku line
// window unit.
// ----------------------------------------------------------------------------
package ilw_pkg;

    localparam int WINDOW_DEF     = 64;
    localparam int PRICE_BITS_DEF = 32;
    localparam int TIME_BITS      = 64;
    localparam int PERIOD_BITS    = 7;
    localparam int KIND_BITS      = 2;
    localparam int CFG_IDX_BITS   = 4;
    localparam int CFG_DATA_BITS  = 7;

    localparam logic [PERIOD_BITS-1:0] SHORT_RESET = PERIOD_BITS'(9);
    localparam logic [PERIOD_BITS-1:0] MID_RESET   = PERIOD_BITS'(26);
    localparam logic [PERIOD_BITS-1:0] LONG_RESET  = PERIOD_BITS'(52);

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_LINE_KIND    = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_SHORT_PERIOD = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_MID_PERIOD   = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG_PERIOD  = CFG_IDX_BITS'(3);

    // line selection codes
    localparam logic [KIND_BITS-1:0] LINE_TENKAN   = 2'd0;
    localparam logic [KIND_BITS-1:0] LINE_KIJUN    = 2'd1;
    localparam logic [KIND_BITS-1:0] LINE_SENKOU_A = 2'd2;
    localparam logic [KIND_BITS-1:0] LINE_SENKOU_B = 2'd3;

endpackage

// ===== rtl/core/ilw_ifs.sv =====
// ----------------------------------------------------------------------------
// ilw_ifs
// Channel interfaces: bar input, configuration write and line result.
// ----------------------------------------------------------------------------
interface ilw_bar_if
    import ilw_pkg::*;
#(
    parameter int PRICE_BITS = PRICE_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [PRICE_BITS-1:0] high_price;
    logic signed [PRICE_BITS-1:0] low_price;
    logic signed [TIME_BITS-1:0]  bar_time;
    logic                         row_valid;
    logic                         start_group;

    modport source (
        output valid, high_price, low_price, bar_time, row_valid, start_group,
        input  ready
    );
    modport sink (
        input  valid, high_price, low_price, bar_time, row_valid, start_group,
        output ready
    );
endinterface

interface ilw_cfg_if
    import ilw_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

interface ilw_line_if
    import ilw_pkg::*;
#(
    parameter int WINDOW     = WINDOW_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF
) ();
    localparam int CNT_W = $clog2(WINDOW + 1);

    logic                         valid;
    logic                         ready;
    logic signed [PRICE_BITS+1:0] line_value;
    logic                         value_valid;
    logic [CNT_W-1:0]             bars_held;

    modport source (output valid, line_value, value_valid, bars_held, input ready);
    modport sink (input valid, line_value, value_valid, bars_held, output ready);
endinterface

// ===== rtl/core/ichimoku_line_window_unit.sv =====
// ----------------------------------------------------------------------------
// ichimoku_line_window_unit
// An accepted bar is loaded into the cells, reduced by the registered max/min
// tree and summed in the pair sum register, then registered at the output once
// any held result is taken; no new bar is taken until that load is done.
// Reset: window empty, line_kind tenkan, periods 9, 26 and 52, no result pending.
// ----------------------------------------------------------------------------
module ichimoku_line_window_unit
    import ilw_pkg::*;
#(
    parameter int WINDOW     = WINDOW_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    ilw_bar_if.sink      bar_in,
    ilw_cfg_if.sink      cfg,
    ilw_line_if.source   line_out
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int LAT   = $clog2(WINDOW) + 1;
    localparam int CW    = $clog2(LAT + 1);
    localparam int OUT_W = PRICE_BITS + 2;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CALC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [KIND_BITS-1:0]   line_kind_reg;
    logic [PERIOD_BITS-1:0] short_reg;
    logic [PERIOD_BITS-1:0] mid_reg;
    logic [PERIOD_BITS-1:0] long_reg;

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] fill_eff;
    logic             full;
    logic             accept;
    logic             load;
    logic             out_load;

    logic [PERIOD_BITS-1:0] short_eff;
    logic [PERIOD_BITS-1:0] mid_eff;
    logic [PERIOD_BITS-1:0] long_eff;
    logic [PERIOD_BITS-1:0] period_a;

    logic                         le     [WINDOW];
    logic signed [TIME_BITS-1:0]  s_time [WINDOW];
    logic signed [PRICE_BITS-1:0] s_high [WINDOW];
    logic signed [PRICE_BITS-1:0] s_low  [WINDOW];
    logic signed [PRICE_BITS-1:0] a_high [WINDOW];
    logic signed [PRICE_BITS-1:0] a_low  [WINDOW];
    logic signed [PRICE_BITS-1:0] b_high [WINDOW];
    logic signed [PRICE_BITS-1:0] b_low  [WINDOW];

    logic signed [PRICE_BITS-1:0] a_max, a_min, b_max, b_min;
    logic signed [PRICE_BITS:0]   sum_a_reg, sum_b_reg;
    logic signed [OUT_W-1:0]      value;

    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] line_value_reg;
    logic                    value_valid_reg;
    logic [CNT_W-1:0]        bars_held_reg;

    // ---------------- configuration ----------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_kind_reg <= LINE_TENKAN;
            short_reg     <= SHORT_RESET;
            mid_reg       <= MID_RESET;
            long_reg      <= LONG_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_LINE_KIND:    line_kind_reg <= cfg.data[KIND_BITS-1:0];
                REG_SHORT_PERIOD: short_reg     <= cfg.data;
                REG_MID_PERIOD:   mid_reg       <= cfg.data;
                REG_LONG_PERIOD:  long_reg      <= cfg.data;
                default:          ;
            endcase
        end
    end

    // a zero period means one bar
    assign short_eff = (short_reg == '0) ? PERIOD_BITS'(1) : short_reg;
    assign mid_eff   = (mid_reg == '0)   ? PERIOD_BITS'(1) : mid_reg;
    assign long_eff  = (long_reg == '0)  ? PERIOD_BITS'(1) : long_reg;

    always_comb
    begin
        unique case (line_kind_reg)
            LINE_KIJUN:    period_a = mid_eff;
            LINE_SENKOU_B: period_a = long_eff;
            default:       period_a = short_eff;
        endcase
    end

    // ---------------- control ----------------
    assign bar_in.ready = (state_reg == ST_IDLE);
    assign accept       = bar_in.valid && bar_in.ready;
    assign load         = accept && bar_in.row_valid;
    assign fill_eff     = bar_in.start_group ? '0 : fill_reg;
    assign full         = (fill_eff == CNT_W'(WINDOW));
    assign out_load     = (state_reg == ST_CALC) && (cnt_reg == CW'(LAT))
                          && (!out_valid_reg || line_out.ready);

    always_comb
    begin
        fill_next = fill_reg;
        if (accept)
        begin
            fill_next = fill_eff;
            if (bar_in.row_valid && !full)
            begin
                fill_next = fill_eff + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CALC;
                    cnt_next   = '0;
                end
            end
            ST_CALC:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
                else if (cnt_reg != CW'(LAT))
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            fill_reg  <= fill_next;
        end
    end

    // ---------------- cell chain ----------------
    for (genvar j = 0; j < WINDOW; j++)
    begin : g_cell
        logic                         le_l, le_r;
        logic signed [TIME_BITS-1:0]  l_time, r_time;
        logic signed [PRICE_BITS-1:0] l_high, r_high, l_low, r_low;

        if (j == 0)
        begin : g_first
            assign le_l   = 1'b1;
            assign l_time = bar_in.bar_time;
            assign l_high = bar_in.high_price;
            assign l_low  = bar_in.low_price;
        end
        else
        begin : g_mid_l
            assign le_l   = le[j-1];
            assign l_time = s_time[j-1];
            assign l_high = s_high[j-1];
            assign l_low  = s_low[j-1];
        end

        if (j == WINDOW - 1)
        begin : g_last
            assign le_r   = 1'b0;
            assign r_time = bar_in.bar_time;
            assign r_high = bar_in.high_price;
            assign r_low  = bar_in.low_price;
        end
        else
        begin : g_mid_r
            assign le_r   = le[j+1];
            assign r_time = s_time[j+1];
            assign r_high = s_high[j+1];
            assign r_low  = s_low[j+1];
        end

        ilw_cell #(
            .IDX        (j),
            .WINDOW     (WINDOW),
            .PRICE_BITS (PRICE_BITS)
        ) u_cell (
            .clk        (clk),
            .load       (load),
            .full       (full),
            .fill_eff   (fill_eff),
            .key_time   (bar_in.bar_time),
            .key_high   (bar_in.high_price),
            .key_low    (bar_in.low_price),
            .le_left    (le_l),
            .left_time  (l_time),
            .left_high  (l_high),
            .left_low   (l_low),
            .le_right   (le_r),
            .right_time (r_time),
            .right_high (r_high),
            .right_low  (r_low),
            .fill_now   (fill_reg),
            .period_a   (period_a),
            .period_b   (mid_eff),
            .le_self    (le[j]),
            .slot_time  (s_time[j]),
            .slot_high  (s_high[j]),
            .slot_low   (s_low[j]),
            .a_high     (a_high[j]),
            .a_low      (a_low[j]),
            .b_high     (b_high[j]),
            .b_low      (b_low[j])
        );
    end

    // ---------------- reduction ----------------
    ilw_tree #(
        .WINDOW     (WINDOW),
        .PRICE_BITS (PRICE_BITS)
    ) u_tree_a (
        .clk    (clk),
        .hi_in  (a_high),
        .lo_in  (a_low),
        .max_hi (a_max),
        .min_lo (a_min)
    );

    ilw_tree #(
        .WINDOW     (WINDOW),
        .PRICE_BITS (PRICE_BITS)
    ) u_tree_b (
        .clk    (clk),
        .hi_in  (b_high),
        .lo_in  (b_low),
        .max_hi (b_max),
        .min_lo (b_min)
    );

    always_ff @(posedge clk)
    begin
        sum_a_reg <= (PRICE_BITS+1)'(a_max) + (PRICE_BITS+1)'(a_min);
        sum_b_reg <= (PRICE_BITS+1)'(b_max) + (PRICE_BITS+1)'(b_min);
    end

    // midpoint kept exact: twice the pair sum, senkou a adds both pairs
    always_comb
    begin
        if (line_kind_reg == LINE_SENKOU_A)
        begin
            value = OUT_W'(sum_a_reg) + OUT_W'(sum_b_reg);
        end
        else
        begin
            value = {sum_a_reg, 1'b0};
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (line_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            line_value_reg  <= (fill_reg == '0) ? '0 : value;
            value_valid_reg <= (fill_reg != '0);
            bars_held_reg   <= fill_reg;
        end
    end

    assign line_out.valid       = out_valid_reg;
    assign line_out.line_value  = line_value_reg;
    assign line_out.value_valid = value_valid_reg;
    assign line_out.bars_held   = bars_held_reg;

endmodule

// ===== rtl/core/ilw_cell.sv =====
// ----------------------------------------------------------------------------
// ilw_cell
// One slot of the time-ordered window. Compares its timestamp with the new
// bar, keeps, shifts from a neighbor or takes the new bar, and presents its
// prices masked to the two active line periods.
// ----------------------------------------------------------------------------
module ilw_cell
    import ilw_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int WINDOW     = WINDOW_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               load,
    input  logic                               full,
    input  logic [$clog2(WINDOW+1)-1:0]        fill_eff,
    input  logic signed [TIME_BITS-1:0]        key_time,
    input  logic signed [PRICE_BITS-1:0]       key_high,
    input  logic signed [PRICE_BITS-1:0]       key_low,
    input  logic                               le_left,
    input  logic signed [TIME_BITS-1:0]        left_time,
    input  logic signed [PRICE_BITS-1:0]       left_high,
    input  logic signed [PRICE_BITS-1:0]       left_low,
    input  logic                               le_right,
    input  logic signed [TIME_BITS-1:0]        right_time,
    input  logic signed [PRICE_BITS-1:0]       right_high,
    input  logic signed [PRICE_BITS-1:0]       right_low,
    input  logic [$clog2(WINDOW+1)-1:0]        fill_now,
    input  logic [PERIOD_BITS-1:0]             period_a,
    input  logic [PERIOD_BITS-1:0]             period_b,
    output logic                               le_self,
    output logic signed [TIME_BITS-1:0]        slot_time,
    output logic signed [PRICE_BITS-1:0]       slot_high,
    output logic signed [PRICE_BITS-1:0]       slot_low,
    output logic signed [PRICE_BITS-1:0]       a_high,
    output logic signed [PRICE_BITS-1:0]       a_low,
    output logic signed [PRICE_BITS-1:0]       b_high,
    output logic signed [PRICE_BITS-1:0]       b_low
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SW    = ((CNT_W > PERIOD_BITS) ? CNT_W : PERIOD_BITS) + 1;
    localparam logic signed [PRICE_BITS-1:0] HI_IDENT = {1'b1, {(PRICE_BITS-1){1'b0}}};
    localparam logic signed [PRICE_BITS-1:0] LO_IDENT = {1'b0, {(PRICE_BITS-1){1'b1}}};

    logic signed [TIME_BITS-1:0]  time_reg;
    logic signed [PRICE_BITS-1:0] high_reg;
    logic signed [PRICE_BITS-1:0] low_reg;
    logic                         occupied;
    logic                         held;
    logic                         in_a;
    logic                         in_b;

    assign occupied = CNT_W'(IDX) < fill_eff;
    assign le_self  = occupied && (time_reg <= key_time);

    // equal timestamps sort after held bars, so a tie keeps its place
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (full)
            begin
                priority if (le_right)
                begin
                    time_reg <= right_time;
                    high_reg <= right_high;
                    low_reg  <= right_low;
                end
                else if (le_self)
                begin
                    time_reg <= key_time;
                    high_reg <= key_high;
                    low_reg  <= key_low;
                end
                else
                begin
                    time_reg <= time_reg;
                end
            end
            else
            begin
                priority if (le_self)
                begin
                    time_reg <= time_reg;
                end
                else if (!le_left)
                begin
                    time_reg <= left_time;
                    high_reg <= left_high;
                    low_reg  <= left_low;
                end
                else
                begin
                    time_reg <= key_time;
                    high_reg <= key_high;
                    low_reg  <= key_low;
                end
            end
        end
    end

    assign slot_time = time_reg;
    assign slot_high = high_reg;
    assign slot_low  = low_reg;

    // slot is among the newest n held bars
    assign held = CNT_W'(IDX) < fill_now;
    assign in_a = held && ((SW'(IDX) + SW'(period_a)) >= SW'(fill_now));
    assign in_b = held && ((SW'(IDX) + SW'(period_b)) >= SW'(fill_now));

    assign a_high = in_a ? high_reg : HI_IDENT;
    assign a_low  = in_a ? low_reg  : LO_IDENT;
    assign b_high = in_b ? high_reg : HI_IDENT;
    assign b_low  = in_b ? low_reg  : LO_IDENT;

endmodule

// ===== rtl/core/ilw_tree.sv =====
// ----------------------------------------------------------------------------
// ilw_tree
// Registered max/min reduction tree: highest high and lowest low over all
// leaves, one register level per pairwise compare.
// ----------------------------------------------------------------------------
module ilw_tree
    import ilw_pkg::*;
#(
    parameter int WINDOW     = WINDOW_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF
)
(
    input  logic                         clk,
    input  logic signed [PRICE_BITS-1:0] hi_in [WINDOW],
    input  logic signed [PRICE_BITS-1:0] lo_in [WINDOW],
    output logic signed [PRICE_BITS-1:0] max_hi,
    output logic signed [PRICE_BITS-1:0] min_lo
);

    localparam int LVL = $clog2(WINDOW);
    localparam int NP  = 1 << LVL;
    localparam logic signed [PRICE_BITS-1:0] HI_IDENT = {1'b1, {(PRICE_BITS-1){1'b0}}};
    localparam logic signed [PRICE_BITS-1:0] LO_IDENT = {1'b0, {(PRICE_BITS-1){1'b1}}};

    logic signed [PRICE_BITS-1:0] hi_lvl [LVL+1][NP];
    logic signed [PRICE_BITS-1:0] lo_lvl [LVL+1][NP];

    // leaves, padded to a power of two with neutral values
    for (genvar k = 0; k < NP; k++)
    begin : g_leaf
        if (k < WINDOW)
        begin : g_real
            assign hi_lvl[0][k] = hi_in[k];
            assign lo_lvl[0][k] = lo_in[k];
        end
        else
        begin : g_pad
            assign hi_lvl[0][k] = HI_IDENT;
            assign lo_lvl[0][k] = LO_IDENT;
        end
    end

    for (genvar l = 0; l < LVL; l++)
    begin : g_level
        for (genvar k = 0; k < (NP >> (l + 1)); k++)
        begin : g_node
            always_ff @(posedge clk)
            begin
                hi_lvl[l+1][k] <= (hi_lvl[l][2*k] > hi_lvl[l][2*k+1]) ?
                                  hi_lvl[l][2*k] : hi_lvl[l][2*k+1];
                lo_lvl[l+1][k] <= (lo_lvl[l][2*k] < lo_lvl[l][2*k+1]) ?
                                  lo_lvl[l][2*k] : lo_lvl[l][2*k+1];
            end
        end
    end

    assign max_hi = hi_lvl[LVL][0];
    assign min_lo = lo_lvl[LVL][0];

endmodule

// ===== dv/tb_ichimoku_line_window_unit.sv =====
// ----------------------------------------------------------------------------
// tb_ichimoku_line_window_unit
// Self-checking bench for the ichimoku line window unit. Bars go in through a
// queue-fed driver with random gaps, results are checked in order against a
// local window model, and the line registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb_ichimoku_line_window_unit;
    import ilw_pkg::*;

    localparam int WIN = WINDOW_DEF;
    localparam int PB  = PRICE_BITS_DEF;

    // indexes with no register behind them
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = CFG_IDX_BITS'(4);
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = CFG_IDX_BITS'(15);

    typedef struct packed {
        logic signed [PB-1:0]        hi;
        logic signed [PB-1:0]        lo;
        logic signed [TIME_BITS-1:0] stamp;
        logic                        row_ok;
        logic                        fresh;
    } bar_t;

    typedef struct packed {
        logic signed [PB+1:0]   value;
        logic                   ok;
        logic [PERIOD_BITS-1:0] held;
    } line_result_t;

    logic clk;
    logic rst_n;

    ilw_bar_if  bar_if ();
    ilw_cfg_if  cfg_if ();
    ilw_line_if line_if ();

    ichimoku_line_window_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .bar_in   (bar_if),
        .cfg      (cfg_if),
        .line_out (line_if)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // window model
    logic signed [TIME_BITS-1:0] win_time [WIN];
    logic signed [PB-1:0]        win_high [WIN];
    logic signed [PB-1:0]        win_low  [WIN];
    int                          win_fill = 0;
    logic [KIND_BITS-1:0]        sel_line = LINE_TENKAN;
    logic [PERIOD_BITS-1:0]      per_short = SHORT_RESET;
    logic [PERIOD_BITS-1:0]      per_mid   = MID_RESET;
    logic [PERIOD_BITS-1:0]      per_long  = LONG_RESET;

    bar_t         bar_queue [$];
    line_result_t due_lines [$];

    logic bar_fire = 1'b0;
    logic cfg_fire = 1'b0;
    logic calm = 1'b0;
    logic press_go = 1'b0;
    logic sink_hold = 1'b0;
    int   bar_gap = 0;
    int   sink_stall = 0;
    int   err_count = 0;
    longint time_cursor = 0;
    logic signed [PB-1:0] price_base = '0;

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // highest high plus lowest low over the newest span bars
    function automatic longint span_sum(input logic [PERIOD_BITS-1:0] span);
        int n;
        int first;
        logic signed [PB-1:0] hh;
        logic signed [PB-1:0] ll;
        n = (span == 0) ? 1 : int'(span);
        first = (win_fill > n) ? win_fill - n : 0;
        hh = win_high[first];
        ll = win_low[first];
        for (int j = first + 1; j < win_fill; j++)
        begin
            if (win_high[j] > hh)
                hh = win_high[j];
            if (win_low[j] < ll)
                ll = win_low[j];
        end
        return longint'(hh) + longint'(ll);
    endfunction

    function automatic void predict_line(input bar_t b);
        int p;
        longint v;
        line_result_t e;
        if (b.fresh)
            win_fill = 0;
        if (b.row_ok)
        begin
            p = 0;
            while (p < win_fill && win_time[p] <= b.stamp)
                p++;
            if (win_fill >= WIN)
            begin
                // full: oldest drops out, a bar older than all is discarded
                if (p > 0)
                begin
                    for (int j = 0; j + 1 < p; j++)
                    begin
                        win_time[j] = win_time[j + 1];
                        win_high[j] = win_high[j + 1];
                        win_low[j]  = win_low[j + 1];
                    end
                    win_time[p - 1] = b.stamp;
                    win_high[p - 1] = b.hi;
                    win_low[p - 1]  = b.lo;
                end
            end
            else
            begin
                for (int j = win_fill; j > p; j--)
                begin
                    win_time[j] = win_time[j - 1];
                    win_high[j] = win_high[j - 1];
                    win_low[j]  = win_low[j - 1];
                end
                win_time[p] = b.stamp;
                win_high[p] = b.hi;
                win_low[p]  = b.lo;
                win_fill++;
            end
        end
        v = 0;
        if (win_fill > 0)
        begin
            case (sel_line)
                LINE_TENKAN:   v = 2 * span_sum(per_short);
                LINE_KIJUN:    v = 2 * span_sum(per_mid);
                LINE_SENKOU_A: v = span_sum(per_short) + span_sum(per_mid);
                default:       v = 2 * span_sum(per_long);
            endcase
        end
        e.value = v[PB+1:0];
        e.ok    = (win_fill > 0);
        e.held  = PERIOD_BITS'(win_fill);
        due_lines = {due_lines, e};
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 30)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    // handshakes, register copy, prediction and result check
    always @(posedge clk)
    begin : capture
        bar_t         seen_bar;
        line_result_t want;
        bar_fire <= rst_n && bar_if.valid && bar_if.ready;
        cfg_fire <= rst_n && cfg_if.valid && cfg_if.ready;
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
            begin
                case (cfg_if.index)
                    REG_LINE_KIND:    sel_line  = cfg_if.data[KIND_BITS-1:0];
                    REG_SHORT_PERIOD: per_short = cfg_if.data;
                    REG_MID_PERIOD:   per_mid   = cfg_if.data;
                    REG_LONG_PERIOD:  per_long  = cfg_if.data;
                    default:          ;
                endcase
            end
            if (bar_if.valid && bar_if.ready)
            begin
                seen_bar.hi     = bar_if.high_price;
                seen_bar.lo     = bar_if.low_price;
                seen_bar.stamp  = bar_if.bar_time;
                seen_bar.row_ok = bar_if.row_valid;
                seen_bar.fresh  = bar_if.start_group;
                predict_line(seen_bar);
            end
            if (line_if.valid && line_if.ready)
            begin
                if (due_lines.size() == 0)
                    report_mismatch("line result with no item outstanding");
                else
                begin
                    want = due_lines.pop_front();
                    if (line_if.line_value !== want.value)
                        report_mismatch($sformatf("line_value %0d, want %0d",
                            line_if.line_value, want.value));
                    if (line_if.value_valid !== want.ok)
                        report_mismatch($sformatf("value_valid %0b, want %0b",
                            line_if.value_valid, want.ok));
                    if (line_if.bars_held !== want.held)
                        report_mismatch($sformatf("bars_held %0d, want %0d",
                            line_if.bars_held, want.held));
                end
            end
        end
    end

    // bar driver
    always @(negedge clk)
    begin
        if (bar_fire)
        begin
            void'(bar_queue.pop_front());
            bar_gap = pick_gap();
        end
        if (!bar_if.valid || bar_fire)
        begin
            if (bar_gap > 0)
            begin
                bar_gap--;
                bar_if.valid <= 1'b0;
            end
            else if (bar_queue.size() > 0)
            begin
                bar_if.high_price  <= bar_queue[0].hi;
                bar_if.low_price   <= bar_queue[0].lo;
                bar_if.bar_time    <= bar_queue[0].stamp;
                bar_if.row_valid   <= bar_queue[0].row_ok;
                bar_if.start_group <= bar_queue[0].fresh;
                bar_if.valid       <= 1'b1;
            end
            else
                bar_if.valid <= 1'b0;
        end
    end

    // result sink
    always @(negedge clk)
    begin
        if (!rst_n || sink_hold)
            line_if.ready <= 1'b0;
        else if (sink_stall > 0)
        begin
            sink_stall--;
            line_if.ready <= 1'b0;
        end
        else
        begin
            line_if.ready <= 1'b1;
            sink_stall = pick_gap();
        end
    end

    // long sink hold-off so the unit backs up and stalls its input
    initial
    begin
        wait (press_go);
        @(posedge clk);
        sink_hold = 1'b1;
        repeat (400) @(posedge clk);
        sink_hold = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL ichimoku_line_window_unit");
        $finish;
    end

    function automatic void queue_bar(input logic signed [PB-1:0] hi,
                                      input logic signed [PB-1:0] lo,
                                      input logic signed [TIME_BITS-1:0] stamp,
                                      input logic row_ok, input logic fresh);
        bar_t b;
        b.hi     = hi;
        b.lo     = lo;
        b.stamp  = stamp;
        b.row_ok = row_ok;
        b.fresh  = fresh;
        bar_queue = {bar_queue, b};
    endfunction

    function automatic void queue_random_bar();
        int r;
        logic fresh;
        logic signed [PB-1:0] hi;
        logic signed [PB-1:0] lo;
        logic signed [TIME_BITS-1:0] stamp;
        fresh = ($urandom_range(0, 99) == 0);
        if (fresh && $urandom_range(0, 1))
            time_cursor = longint'({$urandom, $urandom});
        if ($urandom_range(0, 1))
        begin
            hi = $urandom;
            lo = $urandom;
        end
        else
        begin
            price_base = price_base + $signed($urandom_range(0, 2000)) - 1000;
            hi = price_base + $signed($urandom_range(0, 50));
            lo = price_base - $signed($urandom_range(0, 50));
        end
        // mostly rising stamps, some late, some far out of range
        r = $urandom_range(0, 99);
        if (r < 72)
        begin
            time_cursor = time_cursor + $urandom_range(0, 4);
            stamp = time_cursor;
        end
        else if (r < 84)
            stamp = time_cursor - $urandom_range(1, 150);
        else if (r < 89)
            stamp = time_cursor - 64'sd1_000_000_000;
        else if (r < 94)
            stamp = {$urandom, $urandom};
        else if (r < 97)
            stamp = {1'b1, {(TIME_BITS-1){1'b0}}};
        else
            stamp = {1'b0, {(TIME_BITS-1){1'b1}}};
        queue_bar(hi, lo, stamp, $urandom_range(0, 9) != 0, fresh);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        cfg_if.valid <= 1'b1;
        do @(negedge clk); while (!cfg_fire);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_lines(input logic [CFG_DATA_BITS-1:0] kind,
                             input logic [CFG_DATA_BITS-1:0] s,
                             input logic [CFG_DATA_BITS-1:0] m,
                             input logic [CFG_DATA_BITS-1:0] l);
        write_reg(REG_LINE_KIND, kind);
        write_reg(REG_SHORT_PERIOD, s);
        write_reg(REG_MID_PERIOD, m);
        write_reg(REG_LONG_PERIOD, l);
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (bar_queue.size() != 0 || bar_if.valid || due_lines.size() != 0);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        bar_if.valid        = 1'b0;
        bar_if.high_price   = '0;
        bar_if.low_price    = '0;
        bar_if.bar_time     = '0;
        bar_if.row_valid    = 1'b0;
        bar_if.start_group  = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = '0;
        cfg_if.data         = '0;
        line_if.ready       = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed items at the reset line settings
        queue_bar('0, '0, '0, 1'b0, 1'b0);
        queue_bar('0, '0, '0, 1'b0, 1'b1);
        queue_bar(32'sh7fff_ffff, 32'sh7fff_ffff, '0, 1'b1, 1'b0);
        queue_bar(32'sh8000_0000, 32'sh8000_0000, {1'b0, {63{1'b1}}}, 1'b1, 1'b0);
        queue_bar(32'sh7fff_ffff, 32'sh8000_0000, {1'b1, {63{1'b0}}}, 1'b1, 1'b0);
        queue_bar(32'sd100, -32'sd100, '0, 1'b1, 1'b0);
        queue_bar(32'sh5555_5555, 32'shaaaa_aaaa, 64'sd5, 1'b0, 1'b0);
        queue_bar(32'sd1, -32'sd1, 64'sd10, 1'b1, 1'b1);
        for (int k = 0; k < 11; k++)
            queue_bar(32'sd300 + 32'sd40 * k, 32'sd200 - 32'sd25 * k,
                      64'sd11 + k, 1'b1, 1'b0);
        // equal stamp lands after the held one, late bar lands inside
        queue_bar(32'sd9000, 32'sd8000, 64'sd15, 1'b1, 1'b0);
        queue_bar(-32'sd9000, -32'sd9500, 64'sd12, 1'b1, 1'b0);
        queue_bar('0, '0, '0, 1'b0, 1'b1);
        queue_bar(-32'sd1, -32'sd1, -64'sd1, 1'b1, 1'b0);
        queue_bar(32'sh0000_ffff, 32'shffff_0000, -64'sd1, 1'b1, 1'b0);

        for (int ph = 0; ph < 7; ph++)
        begin
            wait_idle();
            case (ph)
                0: set_lines(CFG_DATA_BITS'(LINE_KIJUN), 7'd1, 7'd64, 7'd127);
                1: set_lines(CFG_DATA_BITS'(LINE_SENKOU_A), 7'd0, 7'd1, 7'd64);
                2: set_lines(CFG_DATA_BITS'(LINE_SENKOU_B), 7'd64, 7'd127, 7'd0);
                3:
                begin
                    // upper data bits of the line select are dropped
                    set_lines({5'b11111, LINE_TENKAN}, 7'd127, 7'd0, 7'd1);
                    write_reg(REG_SPARE_LO, 7'd5);
                    write_reg(REG_SPARE_HI, 7'd127);
                end
                default:
                    set_lines(CFG_DATA_BITS'($urandom_range(0, 127)),
                              CFG_DATA_BITS'($urandom_range(1, 30)),
                              CFG_DATA_BITS'($urandom_range(1, 64)),
                              CFG_DATA_BITS'($urandom_range(0, 127)));
            endcase
            calm = (ph == 3);
            repeat (135) queue_random_bar();
            if (ph == 1)
                press_go = 1'b1;
        end

        wait_idle();
        repeat (20) @(negedge clk);
        if (err_count == 0 && due_lines.size() == 0)
            $display("PASS ichimoku_line_window_unit");
        else
            $display("FAIL ichimoku_line_window_unit");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ilw_pkg.sv
rtl/core/ilw_ifs.sv
rtl/core/ilw_cell.sv
rtl/core/ilw_tree.sv
rtl/core/ichimoku_line_window_unit.sv
dv/tb_ichimoku_line_window_unit.sv
